// ----- rtl/core/pnp_pkg.sv -----
// Shared types, codes and character constants for the prefixed radix number parser.
// Used by pnp_step and prefixed_radix_number_parser_unit; depends on nothing else.
package pnp_pkg;

    // Width of the accumulator; the result is sign-extended or cut from it to 32 bits.
    localparam int VALUE_BITS = 32;
    localparam int RESULT_BITS = 32;

    // Parse phase codes.
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SIGNED = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    // Radix codes.
    localparam logic [1:0] RX_BIN = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_DEC = 2'd2;
    localparam logic [1:0] RX_HEX = 2'd3;

    // ASCII codes that steer the parse.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_DIG0    = 8'h30;
    localparam logic [7:0] CHAR_DIG1    = 8'h31;
    localparam logic [7:0] CHAR_DIG7    = 8'h37;
    localparam logic [7:0] CHAR_DIG9    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic [1:0]            phase;
        logic [1:0]            radix;
        logic                  negative;
        logic                  bad_digit;
        logic [VALUE_BITS-1:0] accum;
    } pnp_state_t;

    // What one byte produces toward the output register.
    typedef struct packed {
        logic                   emit;
        logic                   ok;
        logic [RESULT_BITS-1:0] value;
    } pnp_result_t;

    localparam pnp_state_t STATE_CLEAR = '{
        phase:     PH_START,
        radix:     RX_DEC,
        negative:  1'b0,
        bad_digit: 1'b0,
        accum:     '0
    };

endpackage

// ----- rtl/core/pnp_step.sv -----
// Combinational parse step: applies one byte to the parser state.
// Depends on pnp_pkg for the state and result types and the character codes.
module pnp_step
    import pnp_pkg::*;
(
    input  pnp_state_t  state_cur,
    input  logic [7:0]  char_code,
    input  logic        neg_enable,
    output pnp_state_t  state_next,
    output pnp_result_t result
);

    logic [1:0]            digit_radix;
    logic                  take;
    logic                  is_dec;
    logic                  is_upper;
    logic                  is_lower;
    logic                  good;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] scaled;
    logic [VALUE_BITS-1:0] signed_accum;
    logic [VALUE_BITS-1:0] sum;

    // Classify the byte for every radix in parallel.
    always_comb
    begin
        is_dec   = (char_code >= CHAR_DIG0) && (char_code <= CHAR_DIG9);
        is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);
        is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
    end

    // Phase logic: pick the next phase and radix, and whether the byte is a digit.
    always_comb
    begin
        state_next  = state_cur;
        digit_radix = state_cur.radix;
        take        = 1'b0;
        case (state_cur.phase)
            PH_START, PH_SIGNED:
            begin
                if ((state_cur.phase == PH_START) && (char_code == CHAR_MINUS) && neg_enable)
                begin
                    state_next.negative = 1'b1;
                    state_next.phase    = PH_SIGNED;
                end
                else
                begin
                    state_next.phase = PH_DIGITS;
                    if (char_code == CHAR_DIG0)
                    begin
                        state_next.phase = PH_ZERO;
                    end
                    else if (char_code == CHAR_DOLLAR)
                    begin
                        state_next.radix = RX_HEX;
                    end
                    else if (char_code == CHAR_PERCENT)
                    begin
                        state_next.radix = RX_BIN;
                    end
                    else if (char_code == CHAR_AMP)
                    begin
                        state_next.radix = RX_OCT;
                    end
                    else
                    begin
                        state_next.radix = RX_DEC;
                        digit_radix      = RX_DEC;
                        take             = 1'b1;
                    end
                end
            end
            PH_ZERO:
            begin
                // The accumulator is still zero here, so the leading zero adds nothing.
                state_next.phase = PH_DIGITS;
                if ((char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X))
                begin
                    state_next.radix = RX_HEX;
                end
                else
                begin
                    state_next.radix = RX_DEC;
                    digit_radix      = RX_DEC;
                    take             = 1'b1;
                end
            end
            default:
            begin
                take = 1'b1;
            end
        endcase

        // Digit check and shift-and-add for the selected radix.
        case (digit_radix)
            RX_BIN:
            begin
                good   = (char_code >= CHAR_DIG0) && (char_code <= CHAR_DIG1);
                scaled = state_cur.accum << 1;
            end
            RX_OCT:
            begin
                good   = (char_code >= CHAR_DIG0) && (char_code <= CHAR_DIG7);
                scaled = state_cur.accum << 3;
            end
            RX_DEC:
            begin
                good   = is_dec;
                scaled = (state_cur.accum << 3) + (state_cur.accum << 1);
            end
            default:
            begin
                good   = is_dec || is_upper || is_lower;
                scaled = state_cur.accum << 4;
            end
        endcase
        digit = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
        sum   = scaled + VALUE_BITS'(digit);

        if (take)
        begin
            if (good)
            begin
                state_next.accum = sum;
            end
            else
            begin
                state_next.bad_digit = 1'b1;
            end
        end

        // The terminator emits the result and clears the parse.
        signed_accum = state_cur.negative ? ((~state_cur.accum) + VALUE_BITS'(1))
                                          : state_cur.accum;
        result.emit  = (char_code == CHAR_NUL);
        result.ok    = ~state_cur.bad_digit;
        result.value = state_cur.bad_digit ? '0
                                           : RESULT_BITS'($signed(signed_accum));
        if (char_code == CHAR_NUL)
        begin
            state_next = STATE_CLEAR;
        end
    end

endmodule

// ----- rtl/core/prefixed_radix_number_parser_unit.sv -----
// Top level of the prefixed radix number parser: input register, parse step, result register.
// Depends on pnp_pkg and pnp_step.
//
// The block parses a number string that arrives one byte per transaction on the input
// channel and ends with a zero byte. A leading minus negates the result when neg_enable
// is set; otherwise it counts as a bad digit. A prefix of "0x", "0X" or "$" selects hex
// (letters in either case), "%" selects binary, "&" selects octal, and no prefix means
// decimal. On the zero byte one transaction leaves on the output channel with ok and the
// sign-applied value wrapped to 32 bits; ok is 0 and the value 0 if any byte was not a
// digit of the base. An empty digit run gives ok 1 and value 0. The block takes one byte
// every cycle while the input register is not held: each accepted byte is registered in
// the input register and then folded into the parser state by a single shift-and-add, and a
// terminator passes on into the output register once that register has room. Only a terminator
// that finds the output register still full and stalled holds the input register, and
// with it in_stall. neg_enable is written through the configuration channel, which is
// always ready; write it only while no string is in flight.
module prefixed_radix_number_parser_unit
    import pnp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    neg_enable,
    // Input channel.
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              char_code,
    // Output channel.
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    ok,
    output logic signed [31:0]      result_value
);

    logic                   neg_enable_reg;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [7:0]             s1_char_reg;
    pnp_state_t             state_reg;
    pnp_state_t             state_next;
    pnp_result_t            step_result;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   ok_reg;
    logic [RESULT_BITS-1:0] result_reg;
    logic                   out_free;
    logic                   s1_adv;
    logic                   s1_load;
    logic                   emit;

    assign cfg_ready = 1'b1;

    // The output register can take a new result when it is empty or being drained.
    assign out_free = ~out_valid_reg | ~out_stall;
    // Ordinary bytes always move on; a terminator needs room in the output register.
    assign s1_adv   = s1_valid_reg & ((s1_char_reg != CHAR_NUL) | out_free);
    assign in_stall = s1_valid_reg & ~s1_adv;
    assign s1_load  = in_valid & ~in_stall;
    assign emit     = s1_adv & step_result.emit;

    pnp_step u_step (
        .state_cur  (state_reg),
        .char_code  (s1_char_reg),
        .neg_enable (neg_enable_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (~out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_enable_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_CLEAR;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                neg_enable_reg <= neg_enable;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_char_reg <= char_code;
        end
        if (emit)
        begin
            ok_reg     <= step_result.ok;
            result_reg <= step_result.value;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign result_value = $signed(result_reg);

    // A byte other than the terminator never holds the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_char_reg != CHAR_NUL)) |-> !in_stall)
        else $error("ordinary byte stalled the input register");

    // A consumed terminator leaves the parser in its start state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_char_reg == CHAR_NUL)) |=>
            ((state_reg.phase == PH_START) && (state_reg.accum == '0) && !state_reg.bad_digit))
        else $error("parser state not cleared after terminator");

    // A consumed terminator always produces a valid result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_char_reg == CHAR_NUL)) |=> out_valid)
        else $error("terminator produced no result");

    // A result with a bad digit carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (result_value == 32'sd0))
        else $error("failed parse returned a nonzero value");

endmodule

// ----- test/prefixed_radix_number_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for prefixed_radix_number_parser_unit.
// Depends on pnp_pkg and the parser RTL; a scoreboard class predicts each parsed number.
module prefixed_radix_number_parser_unit_tb;
    import pnp_pkg::*;

    localparam int DRAIN_CYCLES = 4;      // extra wait once no result is owed
    localparam int LONG_HOLD = 300;       // receiver hold-off that backs the pipe up
    localparam int RANDOM_CHARS = 1525;
    localparam int PHASES = 6;
    localparam int TIMEOUT_NS = 8_000_000;

    typedef logic [7:0] text_q_t [$];

    // Tracks the parse state of the string in flight and the numbers still owed.
    class radix_parse_scoreboard;
        typedef struct packed {
            logic        ok;
            logic [31:0] value;
        } parsed_number_t;

        logic [1:0]     phase;
        logic [1:0]     radix;
        logic           negative;
        logic           bad_digit;
        logic [31:0]    accum;
        logic           neg_en;
        parsed_number_t owed[$];
        int             failures;

        function new();
            neg_en = 1'b0;
            failures = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_START;
            radix = RX_DEC;
            negative = 1'b0;
            bad_digit = 1'b0;
            accum = '0;
        endfunction

        function void set_neg_enable(logic v);
            neg_en = v;
        endfunction

        // Folds one character into the accumulator, or marks the string bad.
        function void add_digit(logic [7:0] c);
            logic [4:0] base;
            logic [4:0] d;
            logic       good;
            good = 1'b1;
            d = '0;
            if (radix == RX_HEX) begin
                base = 5'd16;
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
                    d = 5'(c - CHAR_UPPER_A + 8'd10);
                else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
                    d = 5'(c - CHAR_LOWER_A + 8'd10);
                else if (c >= CHAR_DIG0 && c <= CHAR_DIG9)
                    d = 5'(c - CHAR_DIG0);
                else
                    good = 1'b0;
            end
            else begin
                base = (radix == RX_BIN) ? 5'd2 : (radix == RX_OCT) ? 5'd8 : 5'd10;
                good = (c >= CHAR_DIG0) && (c < CHAR_DIG0 + base);
                if (good)
                    d = 5'(c - CHAR_DIG0);
            end
            if (!good)
                bad_digit = 1'b1;
            else
                accum = accum * base + d;
        endfunction

        // Called for every accepted input transaction.
        function void note_char(logic [7:0] c);
            parsed_number_t n;
            if (c == CHAR_NUL) begin
                n.ok = !bad_digit;
                n.value = bad_digit ? 32'd0 : (negative ? -accum : accum);
                owed.push_back(n);
                restart();
                return;
            end
            if (phase == PH_START && c == CHAR_MINUS && neg_en) begin
                negative = 1'b1;
                phase = PH_SIGNED;
            end
            else if (phase == PH_START || phase == PH_SIGNED) begin
                phase = PH_DIGITS;
                if (c == CHAR_DIG0)
                    phase = PH_ZERO;
                else if (c == CHAR_DOLLAR)
                    radix = RX_HEX;
                else if (c == CHAR_PERCENT)
                    radix = RX_BIN;
                else if (c == CHAR_AMP)
                    radix = RX_OCT;
                else begin
                    radix = RX_DEC;
                    add_digit(c);
                end
            end
            else if (phase == PH_ZERO) begin
                phase = PH_DIGITS;
                if (c == CHAR_LOWER_X || c == CHAR_UPPER_X)
                    radix = RX_HEX;
                else begin
                    // A lone leading zero is just the first decimal digit.
                    radix = RX_DEC;
                    add_digit(CHAR_DIG0);
                    add_digit(c);
                end
            end
            else
                add_digit(c);
        endfunction

        // Called for every accepted output transaction.
        function void check_result(logic got_ok, logic [31:0] got_value);
            parsed_number_t n;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result ok %0b value %0d", $time, got_ok,
                         $signed(got_value));
                failures++;
                return;
            end
            n = owed.pop_front();
            if (got_ok !== n.ok) begin
                $display("%0t: ok expected %0b actual %0b", $time, n.ok, got_ok);
                failures++;
            end
            if (got_value !== n.value) begin
                $display("%0t: result_value expected %0d actual %0d", $time,
                         $signed(n.value), $signed(got_value));
                failures++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               neg_enable = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         char_code = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               ok;
    logic signed [31:0] result_value;

    // When set, neither side draws random idle gaps.
    logic               calm = 1'b0;

    radix_parse_scoreboard sb = new();

    prefixed_radix_number_parser_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .neg_enable   (neg_enable),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .result_value (result_value)
    );

    always #4 clk = ~clk;

    // Mostly short idle runs, now and then a long one.
    function automatic int pick_idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] digit_char(logic [1:0] rx);
        int v;
        case (rx)
            RX_BIN: return CHAR_DIG0 + 8'($urandom_range(0, 1));
            RX_OCT: return CHAR_DIG0 + 8'($urandom_range(0, 7));
            RX_DEC: return CHAR_DIG0 + 8'($urandom_range(0, 9));
            default:
            begin
                v = $urandom_range(0, 15);
                if (v < 10)
                    return CHAR_DIG0 + 8'(v);
                return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(v - 10);
            end
        endcase
    endfunction

    // Builds one terminated string: mostly well formed with random digits,
    // sometimes with a corrupted byte, sometimes plain noise.
    function automatic text_q_t make_number_text();
        text_q_t    t;
        int         n;
        logic [1:0] rx;
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(0, 6);
            repeat (n) t.push_back(8'($urandom_range(1, 255)));
        end
        else begin
            if ($urandom_range(0, 3) == 0)
                t.push_back(CHAR_MINUS);
            case ($urandom_range(0, 5))
                0: rx = RX_DEC;
                1:
                begin
                    rx = RX_HEX;
                    t.push_back(CHAR_DOLLAR);
                end
                2:
                begin
                    rx = RX_HEX;
                    t.push_back(CHAR_DIG0);
                    t.push_back(CHAR_LOWER_X);
                end
                3:
                begin
                    rx = RX_HEX;
                    t.push_back(CHAR_DIG0);
                    t.push_back(CHAR_UPPER_X);
                end
                4:
                begin
                    rx = RX_BIN;
                    t.push_back(CHAR_PERCENT);
                end
                default:
                begin
                    rx = RX_OCT;
                    t.push_back(CHAR_AMP);
                end
            endcase
            // Long runs make the accumulator wrap.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            repeat (n) t.push_back(digit_char(rx));
            if (t.size() > 0 && $urandom_range(0, 9) == 0)
                t[$urandom_range(0, t.size() - 1)] =
                    $urandom_range(0, 1) ? CHAR_MINUS : 8'($urandom_range(1, 255));
        end
        t.push_back(CHAR_NUL);
        return t;
    endfunction

    // Offers one character and returns at the edge where it is taken.
    task automatic send_char(logic [7:0] c);
        int gap;
        gap = calm ? 0 : pick_idle_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_char(c);
    endtask

    task automatic send_text(text_q_t t);
        foreach (t[i])
            send_char(t[i]);
    endtask

    // Sender pauses until every owed number is out and the pipe has emptied.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_neg_enable(logic v);
        cfg_valid <= 1'b1;
        neg_enable <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_neg_enable(v);
    endtask

    // Result side: checks every taken transaction and applies back-pressure.
    // Twice it holds off for a long stretch so the input side has to stall.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        int seen;
        stall_left = 0;
        hold_left = 0;
        seen = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                sb.check_result(ok, result_value);
                seen++;
                if (seen == 30 || seen == 150)
                    hold_left = LONG_HOLD;
            end
            if (hold_left == 0 && stall_left == 0 && !calm)
                stall_left = pick_idle_cycles();
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial begin : stimulus
        text_q_t t;
        int      chars_in_phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings with the minus sign disabled (reset value).
        t = '{CHAR_MINUS, "5", CHAR_NUL};                  // minus is a bad digit here
        send_text(t);
        t = '{CHAR_NUL};                                   // empty string
        send_text(t);
        t = '{CHAR_DOLLAR, "f", "F", CHAR_NUL};            // hex, both letter cases
        send_text(t);
        t = '{CHAR_PERCENT, "1", 8'hFF, CHAR_NUL};         // all-ones byte in binary
        send_text(t);

        wait_for_results();
        write_neg_enable(1'b1);
        t = '{CHAR_MINUS, CHAR_DIG0, CHAR_UPPER_X, "1", "a", CHAR_NUL};
        send_text(t);
        t = '{CHAR_AMP, "7", CHAR_MINUS, CHAR_NUL};        // minus inside the digits
        send_text(t);
        t = '{CHAR_DIG0, "9", CHAR_NUL};                   // leading zero, then decimal
        send_text(t);
        t = '{CHAR_MINUS, CHAR_NUL};                       // sign with no digits
        send_text(t);

        // Random phases alternate the sign setting; one runs with no random idle gaps.
        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            write_neg_enable(p[0]);
            calm = (p == 3);
            chars_in_phase = 0;
            while (chars_in_phase < RANDOM_CHARS / PHASES) begin
                t = make_number_text();
                send_text(t);
                chars_in_phase += t.size();
                if ($urandom_range(0, 39) == 0)
                    wait_for_results();
            end
        end
        calm = 1'b0;

        wait_for_results();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- prefixed_radix_number_parser_unit.f -----
rtl/core/pnp_pkg.sv
rtl/core/pnp_step.sv
rtl/core/prefixed_radix_number_parser_unit.sv
test/prefixed_radix_number_parser_unit_tb.sv
